// ===== hw/rtl/acr_pkg.sv =====
`default_nettype none
package acr_pkg;

  localparam int MAX_OBSTACLES = 64;
  localparam int COORD_BITS    = 16;

  localparam int PUSH_W = COORD_BITS + 1;
  localparam int SUM_W  = COORD_BITS + 2;
  localparam int IDX_W  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNT_W  = $clog2(MAX_OBSTACLES + 1);
  localparam int CFG_W  = 7;
  localparam int EIDX_W = 6;

  // Input word layout, lowest bit first.
  localparam int OFF_LEFT     = EIDX_W;
  localparam int OFF_TOP      = OFF_LEFT + COORD_BITS;
  localparam int OFF_RIGHT    = OFF_TOP + COORD_BITS;
  localparam int OFF_BOTTOM   = OFF_RIGHT + COORD_BITS;
  localparam int OFF_POS_X    = OFF_BOTTOM + COORD_BITS;
  localparam int OFF_POS_Y    = OFF_POS_X + COORD_BITS;
  localparam int IN_DATA_BITS = OFF_POS_Y + COORD_BITS;
  localparam int IN_DATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;

  // Result word layout, lowest bit first.
  localparam int OFF_NEW_Y     = COORD_BITS;
  localparam int OFF_PUSH_X    = OFF_NEW_Y + COORD_BITS;
  localparam int OFF_PUSH_Y    = OFF_PUSH_X + PUSH_W;
  localparam int OFF_OVERLAP   = OFF_PUSH_Y + PUSH_W;
  localparam int OUT_DATA_BITS = OFF_OVERLAP + 1;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic signed [COORD_BITS-1:0] right;
    logic signed [COORD_BITS-1:0] bottom;
  } rect_t;

  typedef struct packed {
    logic signed [PUSH_W-1:0] vx;
    logic signed [PUSH_W-1:0] vy;
    logic                     hit;
  } push_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  function automatic logic signed [COORD_BITS-1:0] sat_add(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [PUSH_W-1:0]     v
  );
    logic signed [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(v);
    if (sum > SUM_W'(COORD_MAX)) begin
      return COORD_MAX;
    end else if (sum < SUM_W'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return sum[COORD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aabb_collision_resolver.sv =====
// Obstacle table and collision resolver.
// The in_ channel carries two kinds of word, chosen by in_tuser. A write word
// stores one obstacle rectangle at entry_index and produces no result. A query
// word carries the mover's rectangle and position. The block then reads the
// first obstacle_count table entries (capped at the table depth) one per cycle
// and runs each through the shared push unit; the pushes are added to the
// position with saturation. After a query word is taken, in_tready stays low
// through the RAM reads, push register, accumulate, drain check and result
// load, with no reads when the count is zero. The result word is valid as
// soon as in_tready rises again.
// The result word goes into an output register. The block accepts new words
// while that word waits, but a finished query holds until the register frees,
// so a stalled receiver stops further input once a second query has finished.
// The cfg_ channel writes obstacle_count and is always ready; write it only
// while the block is idle. Reset clears the control state and the count;
// table entries stay undefined until written.
`default_nettype none
module aabb_collision_resolver (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // entry_index, rect_left, rect_top, rect_right, rect_bottom, pos_x, pos_y
  input  wire  [acr_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // new_pos_x, new_pos_y, push_x, push_y, any_overlap
  output logic [acr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [acr_pkg::CFG_W-1:0]       cfg_data
);
  import acr_pkg::*;

  state_t                    state_r, state_nxt;
  logic [CFG_W-1:0]          cfg_count_r;
  logic [CNT_W-1:0]          n_r;
  logic [CNT_W-1:0]          addr_r;
  rect_t                     mov_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic                      v1_r, v2_r;
  logic signed [PUSH_W-1:0]  vx_r, vy_r;
  logic                      hit_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r;

  logic                      in_fire, wr_en, start, issue, load;
  logic [CNT_W-1:0]          n_clamp;
  rect_t                     in_rect, rd_data;
  push_t                     push;

  assign in_rect.left   = in_tdata[OFF_LEFT   +: COORD_BITS];
  assign in_rect.top    = in_tdata[OFF_TOP    +: COORD_BITS];
  assign in_rect.right  = in_tdata[OFF_RIGHT  +: COORD_BITS];
  assign in_rect.bottom = in_tdata[OFF_BOTTOM +: COORD_BITS];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign wr_en      = in_fire && (in_tuser == REQ_WRITE) &&
                      (32'(in_tdata[EIDX_W-1:0]) < MAX_OBSTACLES);
  assign start      = in_fire && (in_tuser == REQ_QUERY);
  assign issue      = (state_r == S_RUN) && (addr_r < n_r);
  assign n_clamp    = (32'(cfg_count_r) > MAX_OBSTACLES) ? CNT_W'(MAX_OBSTACLES)
                                                         : CNT_W'(cfg_count_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  acr_obstacle_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_tdata[EIDX_W-1:0])),
    .wr_data (in_rect),
    .rd_en   (issue),
    .rd_addr (addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  acr_push_unit u_push (
    .obs  (rd_data),
    .mov  (mov_r),
    .push (push)
  );

  always_comb begin
    state_nxt     = state_r;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (!issue && !v1_r && !v2_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_count_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      if (cfg_valid && cfg_ready) begin
        cfg_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mov_r  <= in_rect;
      px_r   <= in_tdata[OFF_POS_X +: COORD_BITS];
      py_r   <= in_tdata[OFF_POS_Y +: COORD_BITS];
      n_r    <= n_clamp;
      addr_r <= '0;
      vx_r   <= '0;
      vy_r   <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (issue) begin
        addr_r <= addr_r + 1'b1;
      end
      if (v1_r) begin
        vx_r  <= push.vx;
        vy_r  <= push.vy;
        hit_r <= hit_r | push.hit;
      end
      if (v2_r) begin
        px_r <= sat_add(px_r, vx_r);
        py_r <= sat_add(py_r, vy_r);
      end
    end
    if (load) begin
      out_data_r <= OUT_DATA_W'({hit_r, vy_r, vx_r, py_r, px_r});
    end
  end

  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (addr_r <= n_r))
    else $error("obstacle address ran past the count");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("push stage valid without a preceding read");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (!v1_r && !v2_r && !issue))
    else $error("query finished with work still in flight");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> $past(state_r == S_DONE))
    else $error("result word loaded outside the finish step");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r) |-> !in_tready)
    else $error("input taken while a query is still running");

endmodule
`default_nettype wire

// ===== hw/rtl/acr_obstacle_ram.sv =====
`default_nettype none
module acr_obstacle_ram (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire  [acr_pkg::IDX_W-1:0]  wr_addr,
  input  acr_pkg::rect_t             wr_data,
  input  wire                        rd_en,
  input  wire  [acr_pkg::IDX_W-1:0]  rd_addr,
  output acr_pkg::rect_t             rd_data
);
  import acr_pkg::*;

  rect_t mem [MAX_OBSTACLES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/acr_push_unit.sv =====
`default_nettype none
module acr_push_unit (
  input  acr_pkg::rect_t obs,
  input  acr_pkg::rect_t mov,
  output acr_pkg::push_t push
);
  import acr_pkg::*;

  logic signed [PUSH_W-1:0] gl, gr, gt, gb;
  logic signed [PUSH_W-1:0] hx, hy;
  logic                     miss;

  function automatic logic signed [PUSH_W-1:0] mag(input logic signed [PUSH_W-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  always_comb begin
    gl = PUSH_W'(obs.left)   - PUSH_W'(mov.right);
    gr = PUSH_W'(obs.right)  - PUSH_W'(mov.left);
    gt = PUSH_W'(obs.top)    - PUSH_W'(mov.bottom);
    gb = PUSH_W'(obs.bottom) - PUSH_W'(mov.top);

    // Touching edges give a zero gap and still count as contact for the push.
    miss = (gl > 0) || (gr < 0) || (gt > 0) || (gb < 0);
    hx   = (mag(gl) < gr) ? gl : gr;
    hy   = (mag(gt) < gb) ? gt : gb;

    push.hit = (gl < 0) && (gr > 0) && (gt < 0) && (gb > 0);
    push.vx  = '0;
    push.vy  = '0;
    if (!miss) begin
      if (mag(hx) < mag(hy)) begin
        push.vx = hx;
      end else begin
        push.vy = hy;
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_aabb_collision_resolver.sv =====
module tb_aabb_collision_resolver;
  import acr_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = MAX_OBSTACLES + 6;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [PUSH_W-1:0]     vx;
    logic signed [PUSH_W-1:0]     vy;
    logic                         hit;
  } move_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  rect_t        obstacle_model [MAX_OBSTACLES];
  int           obstacle_limit = 0;
  move_result_t expected_moves [$];
  int           fail_count = 0;
  int           idle_pct = 29;
  int           rx_stall_ask = 0;
  int           rx_stall_left = 0;
  bit           in_pending = 1'b0;
  int unsigned  cycle_count = 0;

  aabb_collision_resolver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("aabb_collision_resolver test failed");
      $finish;
    end
  end

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > int'(COORD_MAX)) begin
      return int'(COORD_MAX);
    end else if (v < int'(COORD_MIN)) begin
      return int'(COORD_MIN);
    end
    return v;
  endfunction

  // Walks the valid obstacles in order, pushing the mover's position out of
  // each one that it touches or overlaps.
  function automatic move_result_t resolve_mover(input rect_t m,
                                                 input logic signed [COORD_BITS-1:0] px,
                                                 input logic signed [COORD_BITS-1:0] py);
    move_result_t r;
    rect_t        ob;
    int           n, gl, gr, gt, gb, vx, vy, x, y;
    x     = int'(px);
    y     = int'(py);
    vx    = 0;
    vy    = 0;
    r.hit = 1'b0;
    n = (obstacle_limit > MAX_OBSTACLES) ? MAX_OBSTACLES : obstacle_limit;
    for (int i = 0; i < n; i++) begin
      ob = obstacle_model[i];
      gl = int'(ob.left) - int'(m.right);
      gr = int'(ob.right) - int'(m.left);
      gt = int'(ob.top) - int'(m.bottom);
      gb = int'(ob.bottom) - int'(m.top);
      if (m.left < ob.right && m.right > ob.left && m.top < ob.bottom && m.bottom > ob.top) begin
        r.hit = 1'b1;
      end
      vx = 0;
      vy = 0;
      if (gl > 0 || gr < 0 || gt > 0 || gb < 0) begin
        continue;
      end
      vx = (magnitude(gl) < gr) ? gl : gr;
      vy = (magnitude(gt) < gb) ? gt : gb;
      // Only the cheaper axis moves; equal pushes go along y.
      if (magnitude(vx) < magnitude(vy)) begin
        vy = 0;
      end else begin
        vx = 0;
      end
      x = clamp_coord(x + vx);
      y = clamp_coord(y + vy);
    end
    r.x  = x[COORD_BITS-1:0];
    r.y  = y[COORD_BITS-1:0];
    r.vx = vx[PUSH_W-1:0];
    r.vy = vy[PUSH_W-1:0];
    return r;
  endfunction

  function automatic rect_t random_rect();
    rect_t b;
    int    sel, x0, y0, tmp;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      b = rect_t'({$urandom, $urandom});
    end else begin
      // A coarse grid makes touching edges and equal pushes common.
      if (sel < 55) begin
        x0 = 10 * int'($urandom_range(0, 40)) - 200;
        y0 = 10 * int'($urandom_range(0, 40)) - 200;
        b.right  = COORD_BITS'(x0 + 10 * int'($urandom_range(0, 12)));
        b.bottom = COORD_BITS'(y0 + 10 * int'($urandom_range(0, 12)));
      end else begin
        x0 = int'($urandom_range(0, 400)) - 200;
        y0 = int'($urandom_range(0, 400)) - 200;
        b.right  = COORD_BITS'(x0 + int'($urandom_range(0, 120)));
        b.bottom = COORD_BITS'(y0 + int'($urandom_range(0, 120)));
      end
      b.left = COORD_BITS'(x0);
      b.top  = COORD_BITS'(y0);
      if (sel >= 90) begin
        tmp      = int'(b.left);
        b.left   = b.right;
        b.right  = COORD_BITS'(tmp);
        tmp      = int'(b.top);
        b.top    = b.bottom;
        b.bottom = COORD_BITS'(tmp);
      end
    end
    return b;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] random_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      return COORD_BITS'(int'($urandom_range(0, 600)) - 300);
    end else if (sel < 80) begin
      return COORD_BITS'(int'(COORD_MAX) - int'($urandom_range(0, 40)));
    end else if (sel < 90) begin
      return COORD_BITS'(int'(COORD_MIN) + int'($urandom_range(0, 40)));
    end
    return COORD_BITS'($urandom);
  endfunction

  // Offers one word and waits until the block takes it. Valid stays high
  // afterwards so that the next word can follow without a gap.
  task automatic send_word(input logic kind, input logic [EIDX_W-1:0] slot, input rect_t box,
                           input logic signed [COORD_BITS-1:0] px,
                           input logic signed [COORD_BITS-1:0] py);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[EIDX_W-1:0]                = slot;
    word[OFF_LEFT +: COORD_BITS]    = box.left;
    word[OFF_TOP +: COORD_BITS]     = box.top;
    word[OFF_RIGHT +: COORD_BITS]   = box.right;
    word[OFF_BOTTOM +: COORD_BITS]  = box.bottom;
    word[OFF_POS_X +: COORD_BITS]   = px;
    word[OFF_POS_Y +: COORD_BITS]   = py;
    if (!in_pending) begin
      @(negedge clk);
    end
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_WRITE) begin
      obstacle_model[slot] = box;
    end else begin
      expected_moves.push_back(resolve_mover(box, px, py));
    end
    @(negedge clk);
    in_pending = 1'b1;
  endtask

  task automatic write_obstacle(input logic [EIDX_W-1:0] slot, input rect_t box);
    send_word(REQ_WRITE, slot, box, COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic query_mover(input rect_t box, input logic signed [COORD_BITS-1:0] px,
                             input logic signed [COORD_BITS-1:0] py);
    send_word(REQ_QUERY, EIDX_W'($urandom_range(0, MAX_OBSTACLES - 1)), box, px, py);
  endtask

  task automatic hold_input();
    if (in_pending) begin
      in_tvalid <= 1'b0;
      in_pending = 1'b0;
    end
  endtask

  task automatic wait_for_results();
    hold_input();
    while (expected_moves.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_obstacle_count(input int value);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    obstacle_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rx_stall_ask > 0) begin
      rx_stall_left = rx_stall_ask;
      rx_stall_ask  = 0;
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_pct > 0 && $urandom_range(0, 99) < idle_pct);
    end
  end

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    move_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_moves.size() == 0) begin
        $error("result word arrived with no query outstanding");
        fail_count++;
      end else begin
        want = expected_moves.pop_front();
        compare_field("new_pos_x", int'(want.x),
                      int'($signed(out_tdata[0 +: COORD_BITS])));
        compare_field("new_pos_y", int'(want.y),
                      int'($signed(out_tdata[OFF_NEW_Y +: COORD_BITS])));
        compare_field("push_x", int'(want.vx),
                      int'($signed(out_tdata[OFF_PUSH_X +: PUSH_W])));
        compare_field("push_y", int'(want.vy),
                      int'($signed(out_tdata[OFF_PUSH_Y +: PUSH_W])));
        compare_field("any_overlap", int'(want.hit), int'(out_tdata[OFF_OVERLAP]));
      end
    end
  end

  // With the count at its reset value every query returns its own position.
  task automatic test_empty_table();
    query_mover('{-32768, -32768, 32767, 32767}, 32767, -32768);
    query_mover('{0, 0, 0, 0}, -32768, 32767);
    query_mover(random_rect(), 0, -1);
  endtask

  task automatic test_directed_pushes();
    write_obstacle(0, '{0, 0, 100, 100});
    write_obstacle(1, '{-32768, -32768, 32767, 32767});
    write_obstacle(2, '{50, 50, -50, -50});
    write_obstacle(3, '{200, 0, 300, 50});
    write_obstacle(4, '{-32768, 32767, -32768, 32767});
    write_obstacle(5, '{32767, -32768, 32767, -32768});
    write_obstacle(63, '{-1, -1, -1, -1});
    set_obstacle_count(1);
    query_mover('{90, 10, 120, 30}, 0, 0);
    // Touching edges give a zero push and no strict overlap.
    query_mover('{100, 0, 150, 50}, 10, 10);
    query_mover('{-10, -10, 10, 10}, 5, 5);
    // Centered mover: both gaps equal on each axis.
    query_mover('{40, 40, 60, 60}, -32768, 32767);
    set_obstacle_count(6);
    query_mover('{-10, -10, 10, 10}, -32768, -32768);
    query_mover('{-10, -10, 10, 10}, 32767, 32767);
    query_mover('{-32768, -32768, 32767, 32767}, 0, 0);
    query_mover('{250, 20, 260, 60}, 0, 0);
  endtask

  task automatic test_random_traffic();
    int cnt;
    // Load every slot, with queries at the current obstacle count mixed in.
    for (int i = 0; i < MAX_OBSTACLES; i++) begin
      write_obstacle(EIDX_W'(i), random_rect());
      if ($urandom_range(0, 99) < 30) begin
        query_mover(random_rect(), random_coord(), random_coord());
      end
    end
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin
          cnt = MAX_OBSTACLES;
        end
        1: begin
          cnt = (1 << CFG_W) - 1;
        end
        2: begin
          cnt = 0;
        end
        3: begin
          cnt = MAX_OBSTACLES + 1;
        end
        default: begin
          cnt = $urandom_range(1, 16);
        end
      endcase
      set_obstacle_count(cnt);
      idle_pct = (p == 5) ? 0 : 29;
      for (int k = 0; k < 135; k++) begin
        if ($urandom_range(0, 99) < 25) begin
          write_obstacle(EIDX_W'($urandom_range(0, MAX_OBSTACLES - 1)), random_rect());
        end else begin
          query_mover(random_rect(), random_coord(), random_coord());
        end
      end
    end
    idle_pct = 29;
  endtask

  task automatic test_backpressure();
    set_obstacle_count(8);
    // The receiver holds off while words keep coming, so the block fills up.
    rx_stall_ask = 400;
    for (int k = 0; k < 24; k++) begin
      if (k % 4 == 3) begin
        write_obstacle(EIDX_W'($urandom_range(0, MAX_OBSTACLES - 1)), random_rect());
      end else begin
        query_mover(random_rect(), random_coord(), random_coord());
      end
    end
    wait_for_results();
    for (int k = 0; k < 20; k++) begin
      query_mover(random_rect(), random_coord(), random_coord());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = REQ_WRITE;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_directed_pushes();
    test_random_traffic();
    test_backpressure();
    wait_for_results();
    if (fail_count == 0) begin
      $display("aabb_collision_resolver test passed");
    end else begin
      $display("aabb_collision_resolver test failed");
    end
    $finish;
  end

endmodule
